>>> rtl/core/eigen_2x2_solver_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 2x2 eigen solver core
// Shared concurrent assertion forms, clocked by clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EIGEN_2X2_SOLVER_CORE_MACROS_SVH
`define EIGEN_2X2_SOLVER_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define EIG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("eig2 assertion failed");

// Condition in one cycle that requires a consequence in the next cycle.
`define EIG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eig2 assertion failed");

`endif

>>> rtl/core/eig2_pkg.sv
// ----------------------------------------------------------------------------
// eig2_pkg
// Types, constants and step functions shared by the eigen solver pipeline.
// ----------------------------------------------------------------------------
package eig2_pkg;

    localparam int IN_DATA_W   = 128;
    localparam int OUT_DATA_W  = 192;
    localparam int OUT_USER_W  = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_SORT_ENABLE      = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_NORMALIZE_ENABLE = 1'b1;

    // Integer square root: 66-bit radicand, one result bit per stage.
    localparam int SQ_RAD_W  = 66;
    localparam int SQ_ROOT_W = 33;
    localparam int SQ_REM_W  = 36;
    localparam int SQ_STEPS  = 33;

    // Restoring divider for (|component| << 16) / n, one quotient bit per stage.
    localparam int DIV_NUM_W = 48;
    localparam int DIV_Q_W   = 17;

    localparam int MAG_W    = 36;
    localparam int POS_W    = 6;
    localparam int NORM_POS = 30;

    typedef logic signed [31:0] q_t;
    typedef logic signed [32:0] tr_t;
    typedef logic signed [34:0] eig_t;
    typedef logic signed [35:0] comp_t;
    typedef logic [MAG_W-1:0]   mag_t;

    localparam comp_t Q_ONE = 36'sd65536;

    typedef struct packed {
        q_t  a;
        q_t  b;
        q_t  c;
        q_t  d;
        tr_t trace;
        logic complex_root;
    } mat_t;

    typedef struct packed {
        eig_t  [1:0] e;
        comp_t [1:0] x;
        comp_t [1:0] y;
        logic        norm;
        logic        complex_root;
    } pair_t;

    typedef struct packed {
        pair_t             pair;
        logic [1:0][30:0]  ux;
        logic [1:0][30:0]  uy;
        logic [1:0][62:0]  s;
        logic [1:0]        skip;
    } nin_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
        logic [SQ_RAD_W-1:0]  rad;
    } sq_t;

    typedef struct packed {
        logic [DIV_NUM_W-1:0] rem;
        logic [DIV_Q_W-1:0]   quot;
    } dv_t;

    typedef struct packed {
        q_t   val;
        logic sat;
    } sat_t;

    function automatic sq_t sqrt_step(sq_t s);
        sq_t                 o;
        logic [SQ_REM_W-1:0] r4;
        logic [SQ_REM_W-1:0] t;
        r4    = {s.rem[SQ_REM_W-3:0], s.rad[SQ_RAD_W-1 -: 2]};
        t     = {1'b0, s.root, 2'b01};
        o.rad = {s.rad[SQ_RAD_W-3:0], 2'b00};
        if (r4 >= t)
        begin
            o.rem  = r4 - t;
            o.root = {s.root[SQ_ROOT_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = r4;
            o.root = {s.root[SQ_ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic dv_t div_step(dv_t s, logic [SQ_ROOT_W-1:0] den, int unsigned sh);
        dv_t                o;
        logic [DIV_NUM_W:0] dsh;
        dsh = {{(DIV_NUM_W + 1 - SQ_ROOT_W){1'b0}}, den} << sh;
        if ({1'b0, s.rem} >= dsh)
        begin
            o.rem  = s.rem - dsh[DIV_NUM_W-1:0];
            o.quot = {s.quot[DIV_Q_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = s.rem;
            o.quot = {s.quot[DIV_Q_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic sat_t sat32(comp_t v);
        sat_t o;
        if (v[35:31] != 5'b00000 && v[35:31] != 5'b11111)
        begin
            o.sat = 1'b1;
            o.val = v[35] ? 32'sh80000000 : 32'sh7fffffff;
        end
        else
        begin
            o.sat = 1'b0;
            o.val = v[31:0];
        end
        return o;
    endfunction

endpackage

>>> rtl/core/eig2_disc.sv
// ----------------------------------------------------------------------------
// eig2_disc
// Discriminant (a-d)^2 + 4bc and its pipelined integer square root.
// ----------------------------------------------------------------------------
module eig2_disc (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic                               in_valid,
    input  eig2_pkg::q_t                       entry_00,
    input  eig2_pkg::q_t                       entry_01,
    input  eig2_pkg::q_t                       entry_10,
    input  eig2_pkg::q_t                       entry_11,
    output logic                               out_valid,
    output eig2_pkg::mat_t                     out_mat,
    output logic [eig2_pkg::SQ_ROOT_W-1:0]     out_root
);
    import eig2_pkg::*;

    logic              s1_valid_reg;
    mat_t              s1_mat_reg, s1_mat_next;
    logic [31:0]       s1_mdiff_reg, s1_mdiff_next;
    logic [31:0]       s1_mb_reg, s1_mb_next;
    logic [31:0]       s1_mc_reg, s1_mc_next;
    logic              s1_neq_reg, s1_neq_next;
    logic signed [32:0] diff;

    logic              s2_valid_reg;
    mat_t              s2_mat_reg;
    logic [63:0]       s2_sq_reg, s2_sq_next;
    logic [63:0]       s2_bc_reg, s2_bc_next;
    logic              s2_neq_reg;

    logic              s3_valid_reg;
    mat_t              s3_mat_reg, s3_mat_next;
    logic [SQ_RAD_W-1:0] s3_disc_reg, s3_disc_next;
    logic [SQ_RAD_W-1:0] sqw, bc4;

    sq_t               sq_seed;
    sq_t               sq_reg  [SQ_STEPS];
    mat_t              sqm_reg [SQ_STEPS];
    logic              sqv_reg [SQ_STEPS];

    always_comb
    begin
        diff                     = $signed({entry_00[31], entry_00}) -
                                   $signed({entry_11[31], entry_11});
        s1_mat_next.a            = entry_00;
        s1_mat_next.b            = entry_01;
        s1_mat_next.c            = entry_10;
        s1_mat_next.d            = entry_11;
        s1_mat_next.trace        = tr_t'(entry_00) + tr_t'(entry_11);
        s1_mat_next.complex_root = 1'b0;
        s1_mdiff_next            = diff[32] ? 32'(-diff) : 32'(diff);
        s1_mb_next               = entry_01[31] ? 32'(-entry_01) : 32'(entry_01);
        s1_mc_next               = entry_10[31] ? 32'(-entry_10) : 32'(entry_10);
        s1_neq_next              = entry_01[31] ^ entry_10[31];
    end

    always_comb
    begin
        s2_sq_next = s1_mdiff_reg * s1_mdiff_reg;
        s2_bc_next = s1_mb_reg * s1_mc_reg;
    end

    // Opposite signs of b and c subtract; a deficit marks a complex pair.
    always_comb
    begin
        sqw         = {2'b00, s2_sq_reg};
        bc4         = {s2_bc_reg, 2'b00};
        s3_mat_next = s2_mat_reg;
        if (!s2_neq_reg)
        begin
            s3_disc_next = sqw + bc4;
        end
        else if (sqw >= bc4)
        begin
            s3_disc_next = sqw - bc4;
        end
        else
        begin
            s3_disc_next             = '0;
            s3_mat_next.complex_root = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_mat_reg   <= s1_mat_next;
            s1_mdiff_reg <= s1_mdiff_next;
            s1_mb_reg    <= s1_mb_next;
            s1_mc_reg    <= s1_mc_next;
            s1_neq_reg   <= s1_neq_next;
            s2_mat_reg   <= s1_mat_reg;
            s2_sq_reg    <= s2_sq_next;
            s2_bc_reg    <= s2_bc_next;
            s2_neq_reg   <= s1_neq_reg;
            s3_mat_reg   <= s3_mat_next;
            s3_disc_reg  <= s3_disc_next;
        end
    end

    always_comb
    begin
        sq_seed.rem  = '0;
        sq_seed.root = '0;
        sq_seed.rad  = s3_disc_reg;
    end

    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_sqrt
        sq_t  stage_in;
        mat_t mat_in;
        logic valid_in;

        if (i == 0)
        begin : g_first
            assign stage_in = sq_seed;
            assign mat_in   = s3_mat_reg;
            assign valid_in = s3_valid_reg;
        end
        else
        begin : g_next
            assign stage_in = sq_reg[i-1];
            assign mat_in   = sqm_reg[i-1];
            assign valid_in = sqv_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sqv_reg[i] <= 1'b0;
            else if (advance)
                sqv_reg[i] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                sq_reg[i]  <= sqrt_step(stage_in);
                sqm_reg[i] <= mat_in;
            end
        end
    end

    assign out_valid = sqv_reg[SQ_STEPS-1];
    assign out_mat   = sqm_reg[SQ_STEPS-1];
    assign out_root  = sq_reg[SQ_STEPS-1].root;

endmodule

>>> rtl/core/eig2_vec.sv
// ----------------------------------------------------------------------------
// eig2_vec
// Eigenvalues, raw eigenvectors, magnitude scaling and sums of squares.
// ----------------------------------------------------------------------------
module eig2_vec (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           normalize_enable,
    input  logic                           in_valid,
    input  eig2_pkg::mat_t                 in_mat,
    input  logic [eig2_pkg::SQ_ROOT_W-1:0] in_root,
    output logic                           out_valid,
    output eig2_pkg::nin_t                 out_nin
);
    import eig2_pkg::*;

    logic             v1_valid_reg, v2_valid_reg, v3_valid_reg, v4_valid_reg;
    logic             v5_valid_reg, v6_valid_reg, v7_valid_reg;

    mat_t             v1_mat_reg;
    eig_t [1:0]       v1_e_reg, v1_e_next;
    eig_t             t35, r35;

    pair_t            v2_pair_reg, v2_pair_next;
    pair_t            v3_pair_reg, v4_pair_reg, v5_pair_reg, v6_pair_reg;

    mag_t [1:0]       v3_ux_reg, v3_ux_next, v3_uy_reg, v3_uy_next;
    mag_t [1:0]       v4_ux_reg, v4_uy_reg;
    logic [1:0][POS_W-1:0] v4_pos_reg, v4_pos_next;
    logic [1:0]       v4_zero_reg, v4_zero_next;

    logic [1:0][30:0] v5_ux_reg, v5_ux_next, v5_uy_reg, v5_uy_next;
    logic [1:0]       v5_skip_reg;

    logic [1:0][30:0] v6_ux_reg, v6_uy_reg;
    logic [1:0][61:0] v6_sqx_reg, v6_sqx_next, v6_sqy_reg, v6_sqy_next;
    logic [1:0]       v6_skip_reg;

    nin_t             v7_nin_reg, v7_nin_next;

    // Floor halving of trace +- root by arithmetic shift.
    always_comb
    begin
        t35          = eig_t'(in_mat.trace);
        r35          = eig_t'({1'b0, in_root});
        v1_e_next[0] = (t35 + r35) >>> 1;
        v1_e_next[1] = (t35 - r35) >>> 1;
    end

    always_comb
    begin
        logic first_up;
        v2_pair_next.e            = v1_e_reg;
        v2_pair_next.complex_root = v1_mat_reg.complex_root;
        v2_pair_next.norm         = normalize_enable &&
                                    (v1_mat_reg.c != 0 || v1_mat_reg.b != 0);
        for (int l = 0; l < 2; l++)
        begin
            first_up = (v1_mat_reg.d != 0) ^ (l == 1);
            if (v1_mat_reg.c != 0)
            begin
                v2_pair_next.x[l] = comp_t'(v1_e_reg[l]) - comp_t'(v1_mat_reg.d);
                v2_pair_next.y[l] = comp_t'(v1_mat_reg.c);
            end
            else if (v1_mat_reg.b != 0)
            begin
                v2_pair_next.x[l] = comp_t'(v1_mat_reg.b);
                v2_pair_next.y[l] = comp_t'(v1_e_reg[l]) - comp_t'(v1_mat_reg.a);
            end
            else
            begin
                v2_pair_next.x[l] = first_up ? '0 : Q_ONE;
                v2_pair_next.y[l] = first_up ? Q_ONE : '0;
            end
        end
    end

    always_comb
    begin
        comp_t cx;
        comp_t cy;
        for (int l = 0; l < 2; l++)
        begin
            cx            = v2_pair_reg.x[l];
            cy            = v2_pair_reg.y[l];
            v3_ux_next[l] = cx[35] ? mag_t'(-cx) : mag_t'(cx);
            v3_uy_next[l] = cy[35] ? mag_t'(-cy) : mag_t'(cy);
        end
    end

    always_comb
    begin
        mag_t m;
        for (int l = 0; l < 2; l++)
        begin
            m              = (v3_ux_reg[l] > v3_uy_reg[l]) ? v3_ux_reg[l] : v3_uy_reg[l];
            v4_pos_next[l] = '0;
            for (int k = 0; k < MAG_W; k++)
            begin
                if (m[k])
                    v4_pos_next[l] = POS_W'(k);
            end
            v4_zero_next[l] = (m == '0);
        end
    end

    // Both components move by the shift that puts the larger one in [2^30, 2^31).
    always_comb
    begin
        logic [POS_W-1:0] sh;
        for (int l = 0; l < 2; l++)
        begin
            if (v4_pos_reg[l] > POS_W'(NORM_POS))
            begin
                sh            = v4_pos_reg[l] - POS_W'(NORM_POS);
                v5_ux_next[l] = 31'(v4_ux_reg[l] >> sh);
                v5_uy_next[l] = 31'(v4_uy_reg[l] >> sh);
            end
            else
            begin
                sh            = POS_W'(NORM_POS) - v4_pos_reg[l];
                v5_ux_next[l] = 31'(v4_ux_reg[l] << sh);
                v5_uy_next[l] = 31'(v4_uy_reg[l] << sh);
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            v6_sqx_next[l] = v5_ux_reg[l] * v5_ux_reg[l];
            v6_sqy_next[l] = v5_uy_reg[l] * v5_uy_reg[l];
        end
    end

    always_comb
    begin
        v7_nin_next.pair = v6_pair_reg;
        v7_nin_next.ux   = v6_ux_reg;
        v7_nin_next.uy   = v6_uy_reg;
        v7_nin_next.skip = v6_skip_reg;
        for (int l = 0; l < 2; l++)
            v7_nin_next.s[l] = 63'(v6_sqx_reg[l]) + 63'(v6_sqy_reg[l]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_valid_reg <= 1'b0;
            v2_valid_reg <= 1'b0;
            v3_valid_reg <= 1'b0;
            v4_valid_reg <= 1'b0;
            v5_valid_reg <= 1'b0;
            v6_valid_reg <= 1'b0;
            v7_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_valid_reg <= in_valid;
            v2_valid_reg <= v1_valid_reg;
            v3_valid_reg <= v2_valid_reg;
            v4_valid_reg <= v3_valid_reg;
            v5_valid_reg <= v4_valid_reg;
            v6_valid_reg <= v5_valid_reg;
            v7_valid_reg <= v6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            v1_mat_reg  <= in_mat;
            v1_e_reg    <= v1_e_next;
            v2_pair_reg <= v2_pair_next;
            v3_pair_reg <= v2_pair_reg;
            v3_ux_reg   <= v3_ux_next;
            v3_uy_reg   <= v3_uy_next;
            v4_pair_reg <= v3_pair_reg;
            v4_ux_reg   <= v3_ux_reg;
            v4_uy_reg   <= v3_uy_reg;
            v4_pos_reg  <= v4_pos_next;
            v4_zero_reg <= v4_zero_next;
            v5_pair_reg <= v4_pair_reg;
            v5_ux_reg   <= v5_ux_next;
            v5_uy_reg   <= v5_uy_next;
            v5_skip_reg <= v4_zero_reg;
            v6_pair_reg <= v5_pair_reg;
            v6_ux_reg   <= v5_ux_reg;
            v6_uy_reg   <= v5_uy_reg;
            v6_sqx_reg  <= v6_sqx_next;
            v6_sqy_reg  <= v6_sqy_next;
            v6_skip_reg <= v5_skip_reg;
            v7_nin_reg  <= v7_nin_next;
        end
    end

    assign out_valid = v7_valid_reg;
    assign out_nin   = v7_nin_reg;

endmodule

>>> rtl/core/eig2_norm.sv
// ----------------------------------------------------------------------------
// eig2_norm
// Vector length by pipelined square root, then four pipelined dividers.
// ----------------------------------------------------------------------------
`include "eigen_2x2_solver_core_macros.svh"

module eig2_norm (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             in_valid,
    input  eig2_pkg::nin_t   in_nin,
    output logic             out_valid,
    output eig2_pkg::pair_t  out_pair
);
    import eig2_pkg::*;

    sq_t [1:0]  sq_seed;
    sq_t [1:0]  nsq_reg  [SQ_STEPS];
    nin_t       nmid_reg [SQ_STEPS];
    logic       nv_reg   [SQ_STEPS];

    dv_t [3:0]                    dv_seed;
    logic [1:0][SQ_ROOT_W-1:0]    dn_seed;
    dv_t [3:0]                    dv_reg    [DIV_Q_W];
    logic [1:0][SQ_ROOT_W-1:0]    dn_reg    [DIV_Q_W];
    pair_t                        dp_reg    [DIV_Q_W];
    logic [1:0]                   dskip_reg [DIV_Q_W];
    logic                         dvv_reg   [DIV_Q_W];

    logic   out_valid_reg;
    pair_t  out_pair_reg, out_pair_next;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            sq_seed[l].rem  = '0;
            sq_seed[l].root = '0;
            sq_seed[l].rad  = {3'b000, in_nin.s[l]};
        end
    end

    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_sqrt
        sq_t [1:0] stage_in;
        nin_t      nin_in;
        logic      valid_in;

        if (i == 0)
        begin : g_first
            assign stage_in = sq_seed;
            assign nin_in   = in_nin;
            assign valid_in = in_valid;
        end
        else
        begin : g_next
            assign stage_in = nsq_reg[i-1];
            assign nin_in   = nmid_reg[i-1];
            assign valid_in = nv_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                nv_reg[i] <= 1'b0;
            else if (advance)
                nv_reg[i] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                nsq_reg[i][0] <= sqrt_step(stage_in[0]);
                nsq_reg[i][1] <= sqrt_step(stage_in[1]);
                nmid_reg[i]   <= nin_in;
            end
        end
    end

    // Divider lanes: 2*l holds x of vector l, 2*l+1 holds y.
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            dv_seed[2*l].rem    = {1'b0, nmid_reg[SQ_STEPS-1].ux[l], 16'h0000};
            dv_seed[2*l].quot   = '0;
            dv_seed[2*l+1].rem  = {1'b0, nmid_reg[SQ_STEPS-1].uy[l], 16'h0000};
            dv_seed[2*l+1].quot = '0;
            dn_seed[l]          = nsq_reg[SQ_STEPS-1][l].root;
        end
    end

    for (genvar k = 0; k < DIV_Q_W; k++)
    begin : g_div
        dv_t [3:0]                 stage_in;
        logic [1:0][SQ_ROOT_W-1:0] den_in;
        pair_t                     pair_in;
        logic [1:0]                skip_in;
        logic                      valid_in;

        if (k == 0)
        begin : g_first
            assign stage_in = dv_seed;
            assign den_in   = dn_seed;
            assign pair_in  = nmid_reg[SQ_STEPS-1].pair;
            assign skip_in  = nmid_reg[SQ_STEPS-1].skip;
            assign valid_in = nv_reg[SQ_STEPS-1];
        end
        else
        begin : g_next
            assign stage_in = dv_reg[k-1];
            assign den_in   = dn_reg[k-1];
            assign pair_in  = dp_reg[k-1];
            assign skip_in  = dskip_reg[k-1];
            assign valid_in = dvv_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dvv_reg[k] <= 1'b0;
            else if (advance)
                dvv_reg[k] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                for (int j = 0; j < 4; j++)
                    dv_reg[k][j] <= div_step(stage_in[j], den_in[j/2], DIV_Q_W - 1 - k);
                dn_reg[k]    <= den_in;
                dp_reg[k]    <= pair_in;
                dskip_reg[k] <= skip_in;
            end
        end
    end

    // Components keep their sign; unnormalized paths pass the raw vectors.
    always_comb
    begin
        comp_t qx;
        comp_t qy;
        out_pair_next = dp_reg[DIV_Q_W-1];
        for (int l = 0; l < 2; l++)
        begin
            qx = comp_t'(dv_reg[DIV_Q_W-1][2*l].quot);
            qy = comp_t'(dv_reg[DIV_Q_W-1][2*l+1].quot);
            if (dp_reg[DIV_Q_W-1].norm && !dskip_reg[DIV_Q_W-1][l] &&
                dn_reg[DIV_Q_W-1][l] != '0)
            begin
                out_pair_next.x[l] = dp_reg[DIV_Q_W-1].x[l][35] ? -qx : qx;
                out_pair_next.y[l] = dp_reg[DIV_Q_W-1].y[l][35] ? -qy : qy;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= dvv_reg[DIV_Q_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_pair_reg <= out_pair_next;
    end

    assign out_valid = out_valid_reg;
    assign out_pair  = out_pair_reg;

    `EIG_ASSERT(a_unit_bound_x0, dvv_reg[DIV_Q_W-1] && !dskip_reg[DIV_Q_W-1][0] |-> dv_reg[DIV_Q_W-1][0].quot <= 17'h10000)
    `EIG_ASSERT(a_root_range, nv_reg[SQ_STEPS-1] && !nmid_reg[SQ_STEPS-1].skip[1] |-> nsq_reg[SQ_STEPS-1][1].root[32:30] != 3'b000)
    `EIG_ASSERT_NEXT(a_div_to_out, advance && dvv_reg[DIV_Q_W-1], out_valid_reg)

endmodule

>>> rtl/core/eigen_2x2_solver_core.sv
// Throughput: one matrix per cycle; every stage is a register and the whole
// pipeline advances when its output register is empty or being taken.
// The depth is set by the two 33-step square root pipelines and the 17-step divider.
// Reset clears all valid bits; sort_enable and normalize_enable reset to 1.
// ----------------------------------------------------------------------------
// eigen_2x2_solver_core
// Eigenvalues and eigenvectors of a signed Q16.16 2x2 matrix, fully pipelined.
// ----------------------------------------------------------------------------
`include "eigen_2x2_solver_core_macros.svh"

module eigen_2x2_solver_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // entry_00, entry_01, entry_10, entry_11 (32 bits each)
    input  logic [eig2_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // eig_first, eig_second, vec_first_x, vec_first_y, vec_second_x, vec_second_y
    output logic [eig2_pkg::OUT_DATA_W-1:0]    m_tdata,
    // complex_flag, saturate_flag
    output logic [eig2_pkg::OUT_USER_W-1:0]    m_tuser,
    input  logic                               cfg_we,
    input  logic [eig2_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [eig2_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import eig2_pkg::*;

    logic    sort_enable_reg, normalize_enable_reg;
    logic    advance;

    logic    disc_valid;
    mat_t    disc_mat;
    logic [SQ_ROOT_W-1:0] disc_root;
    logic    vec_valid;
    nin_t    vec_nin;
    logic    norm_valid;
    pair_t   norm_pair;

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [OUT_USER_W-1:0] m_tuser_reg, m_tuser_next;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_enable_reg      <= 1'b1;
            normalize_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SORT_ENABLE:      sort_enable_reg      <= cfg_wdata[0];
                REG_NORMALIZE_ENABLE: normalize_enable_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    eig2_disc u_disc (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (s_tvalid),
        .entry_00 (s_tdata[31:0]),
        .entry_01 (s_tdata[63:32]),
        .entry_10 (s_tdata[95:64]),
        .entry_11 (s_tdata[127:96]),
        .out_valid(disc_valid),
        .out_mat  (disc_mat),
        .out_root (disc_root)
    );

    eig2_vec u_vec (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .normalize_enable(normalize_enable_reg),
        .in_valid        (disc_valid),
        .in_mat          (disc_mat),
        .in_root         (disc_root),
        .out_valid       (vec_valid),
        .out_nin         (vec_nin)
    );

    eig2_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (vec_valid),
        .in_nin   (vec_nin),
        .out_valid(norm_valid),
        .out_pair (norm_pair)
    );

    // Equal eigenvalues never swap.
    always_comb
    begin
        logic  swap;
        sat_t  se1, se2, sx1, sy1, sx2, sy2;
        swap = sort_enable_reg && (norm_pair.e[0] < norm_pair.e[1]);
        se1  = sat32(comp_t'(swap ? norm_pair.e[1] : norm_pair.e[0]));
        se2  = sat32(comp_t'(swap ? norm_pair.e[0] : norm_pair.e[1]));
        sx1  = sat32(swap ? norm_pair.x[1] : norm_pair.x[0]);
        sy1  = sat32(swap ? norm_pair.y[1] : norm_pair.y[0]);
        sx2  = sat32(swap ? norm_pair.x[0] : norm_pair.x[1]);
        sy2  = sat32(swap ? norm_pair.y[0] : norm_pair.y[1]);
        m_tdata_next = {sy2.val, sx2.val, sy1.val, sx1.val, se2.val, se1.val};
        m_tuser_next = {se1.sat | se2.sat | sx1.sat | sy1.sat | sx2.sat | sy2.sat,
                        norm_pair.complex_root};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (advance)
            m_tvalid_reg <= norm_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `EIG_ASSERT(a_complex_equal_roots, m_tvalid_reg && m_tuser_reg[0] |-> m_tdata_reg[31:0] == m_tdata_reg[63:32])
    `EIG_ASSERT(a_roots_ordered, m_tvalid_reg |-> $signed(m_tdata_reg[31:0]) >= $signed(m_tdata_reg[63:32]))
    `EIG_ASSERT_NEXT(a_out_hold, m_tvalid_reg && !m_tready, m_tvalid_reg && $stable(m_tdata_reg))

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 2x2 eigen solver core
// Streams matrices into the core with random gaps and back-pressure, predicts
// each result in the bench unless a typed row gives it, compares all in order.
// ----------------------------------------------------------------------------
module tb_top;

    import eig2_pkg::*;

    typedef struct {
        q_t   e1;
        q_t   e2;
        q_t   x1;
        q_t   y1;
        q_t   x2;
        q_t   y2;
        logic cplx;
        logic sat;
    } eig_result_t;

    typedef struct {
        q_t          a;
        q_t          b;
        q_t          c;
        q_t          d;
        bit          typed;
        eig_result_t want;
    } matrix_row_t;

    localparam q_t QMAX = 32'sh7fffffff;
    localparam q_t QMIN = 32'sh80000000;
    localparam q_t ONE  = 32'sd65536;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic [OUT_USER_W-1:0]   m_tuser;
    logic                    cfg_we;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;

    eig_result_t  pending_results[$];
    matrix_row_t  directed_rows[$];
    int           error_count;
    bit           sort_on;
    bit           norm_on;
    bit           rx_no_stall;

    eigen_2x2_solver_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("eigen_2x2_solver_core: mismatch");
        $finish;
    end

    // Floor square root of a value below 2^72.
    function automatic longint isqrt(logic [79:0] v);
        logic [79:0] root;
        logic [79:0] cand;
        root = '0;
        for (int i = 36; i >= 0; i--)
        begin
            cand = root | (80'd1 << i);
            if (cand * cand <= v)
                root = cand;
        end
        return longint'(root);
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Scales the vector so the larger magnitude sits in [2^30, 2^31) before
    // taking its length, then divides each component by that length.
    function automatic void unit_scale(inout longint x, inout longint y);
        longint ux;
        longint uy;
        longint m;
        longint n;
        ux = abs64(x);
        uy = abs64(y);
        m = ux > uy ? ux : uy;
        if (m == 0)
            return;
        while (m >= (64'sd1 <<< 31))
        begin
            ux = ux >>> 1;
            uy = uy >>> 1;
            m = m >>> 1;
        end
        while (m < (64'sd1 <<< 30))
        begin
            ux = ux <<< 1;
            uy = uy <<< 1;
            m = m <<< 1;
        end
        n = isqrt(80'(ux * ux + uy * uy));
        if (n == 0)
            return;
        x = x < 0 ? -((ux <<< 16) / n) : (ux <<< 16) / n;
        y = y < 0 ? -((uy <<< 16) / n) : (uy <<< 16) / n;
    endfunction

    function automatic q_t clamp32(longint v, inout logic sat);
        if (v > longint'(QMAX))
        begin
            sat = 1'b1;
            return QMAX;
        end
        if (v < longint'(QMIN))
        begin
            sat = 1'b1;
            return QMIN;
        end
        return q_t'(v);
    endfunction

    function automatic eig_result_t solve_eigen(q_t qa, q_t qb, q_t qc, q_t qd);
        eig_result_t res;
        longint      a;
        longint      b;
        longint      c;
        longint      d;
        longint      trace;
        longint      r;
        longint      e1;
        longint      e2;
        longint      x1;
        longint      y1;
        longint      x2;
        longint      y2;
        longint      t;
        logic [79:0] disc;
        logic [79:0] bc4;
        bit          norm;
        a = qa;
        b = qb;
        c = qc;
        d = qd;
        norm = norm_on;
        res.cplx = 1'b0;
        res.sat = 1'b0;
        trace = a + d;
        disc = 80'(abs64(a - d)) * 80'(abs64(a - d));
        bc4 = (80'(abs64(b)) * 80'(abs64(c))) << 2;
        r = 0;
        if ((b < 0) == (c < 0))
            disc = disc + bc4;
        else if (disc >= bc4)
            disc = disc - bc4;
        else
            res.cplx = 1'b1;
        if (!res.cplx)
            r = isqrt(disc);
        e1 = (trace + r) >>> 1;
        e2 = (trace - r) >>> 1;
        if (c != 0)
        begin
            x1 = e1 - d;
            y1 = c;
            x2 = e2 - d;
            y2 = c;
        end
        else if (b != 0)
        begin
            x1 = b;
            y1 = e1 - a;
            x2 = b;
            y2 = e2 - a;
        end
        else
        begin
            // Diagonal matrix: fixed unit vectors, never normalized.
            norm = 1'b0;
            if (d != 0)
            begin
                x1 = 0; y1 = ONE; x2 = ONE; y2 = 0;
            end
            else
            begin
                x1 = ONE; y1 = 0; x2 = 0; y2 = ONE;
            end
        end
        if (norm)
        begin
            unit_scale(x1, y1);
            unit_scale(x2, y2);
        end
        if (sort_on && e1 < e2)
        begin
            t = e1; e1 = e2; e2 = t;
            t = x1; x1 = x2; x2 = t;
            t = y1; y1 = y2; y2 = t;
        end
        res.e1 = clamp32(e1, res.sat);
        res.e2 = clamp32(e2, res.sat);
        res.x1 = clamp32(x1, res.sat);
        res.y1 = clamp32(y1, res.sat);
        res.x2 = clamp32(x2, res.sat);
        res.y2 = clamp32(y2, res.sat);
        return res;
    endfunction

    task automatic report(string field, longint got, longint want);
        error_count++;
        $display("t=%0t %s: got %0d, want %0d", $realtime, field, got, want);
    endtask

    // Result side: ready toggles at the clock edge, the handshake is sampled
    // at the falling edge where everything has settled.
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_no_stall)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
                if (gap == 0)
                begin
                    m_tready <= 1'b1;
                end
                else
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        eig_result_t want;
        eig_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.e1 = m_tdata[31:0];
            got.e2 = m_tdata[63:32];
            got.x1 = m_tdata[95:64];
            got.y1 = m_tdata[127:96];
            got.x2 = m_tdata[159:128];
            got.y2 = m_tdata[191:160];
            got.cplx = m_tuser[0];
            got.sat = m_tuser[1];
            if (pending_results.size() == 0)
            begin
                report("unexpected result", 0, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.e1 !== want.e1) report("eig_first", got.e1, want.e1);
                if (got.e2 !== want.e2) report("eig_second", got.e2, want.e2);
                if (got.x1 !== want.x1) report("vec_first_x", got.x1, want.x1);
                if (got.y1 !== want.y1) report("vec_first_y", got.y1, want.y1);
                if (got.x2 !== want.x2) report("vec_second_x", got.x2, want.x2);
                if (got.y2 !== want.y2) report("vec_second_y", got.y2, want.y2);
                if (got.cplx !== want.cplx) report("complex_flag", got.cplx, want.cplx);
                if (got.sat !== want.sat) report("saturate_flag", got.sat, want.sat);
            end
        end
    end

    task automatic send_matrix(q_t a, q_t b, q_t c, q_t d, bit typed, eig_result_t want,
                               bit no_gaps);
        eig_result_t res;
        int          gap;
        res = typed ? want : solve_eigen(a, b, c, d);
        s_tdata <= {d, c, b, a};
        s_tvalid <= 1'b1;
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        pending_results.push_back(res);
        gap = 0;
        if (!no_gaps)
            gap = ($urandom_range(0, 24) == 0) ? $urandom_range(10, 40)
                                               : ($urandom_range(0, 2) == 0 ?
                                                  $urandom_range(1, 3) : 0);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, bit val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == REG_SORT_ENABLE)
            sort_on = val;
        else
            norm_on = val;
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (110) @(posedge clk);
    endtask

    function automatic q_t rand_entry();
        case ($urandom_range(0, 9)) inside
            0:       return 0;
            1:       return QMAX;
            2:       return QMIN;
            [3:4]:   return q_t'($urandom);
            5:       return q_t'($urandom_range(0, 255)) - 128;
            default: return (q_t'($urandom_range(0, 15)) - 8) * ONE
                            + q_t'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic eig_result_t mk_result(q_t e1, q_t e2, q_t x1, q_t y1, q_t x2,
                                              q_t y2, logic cplx);
        eig_result_t r;
        r.e1 = e1; r.e2 = e2; r.x1 = x1; r.y1 = y1; r.x2 = x2; r.y2 = y2;
        r.cplx = cplx;
        r.sat = 1'b0;
        return r;
    endfunction

    function automatic matrix_row_t mk_row(q_t a, q_t b, q_t c, q_t d, bit typed,
                                           eig_result_t want);
        matrix_row_t row;
        row.a = a; row.b = b; row.c = c; row.d = d;
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    initial
    begin
        eig_result_t none;
        q_t          a;
        q_t          b;
        q_t          c;
        q_t          d;
        bit          no_gaps;
        none = mk_result(0, 0, 0, 0, 0, 0, 0);
        error_count = 0;
        sort_on = 1'b1;
        norm_on = 1'b1;
        rx_no_stall = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;

        // Zero matrix and diagonal matrices give the fixed unit vectors.
        directed_rows.push_back(mk_row(0, 0, 0, 0, 1,
                                       mk_result(0, 0, ONE, 0, 0, ONE, 0)));
        directed_rows.push_back(mk_row(ONE, 0, 0, ONE, 1,
                                       mk_result(ONE, ONE, 0, ONE, ONE, 0, 0)));
        directed_rows.push_back(mk_row(QMAX, 0, 0, QMAX, 1,
                                       mk_result(QMAX, QMAX, 0, ONE, ONE, 0, 0)));
        directed_rows.push_back(mk_row(QMIN, 0, 0, QMIN, 1,
                                       mk_result(QMIN, QMIN, 0, ONE, ONE, 0, 0)));
        directed_rows.push_back(mk_row(QMAX, 0, 0, QMIN, 1,
                                       mk_result(QMAX, QMIN, 0, ONE, ONE, 0, 0)));
        directed_rows.push_back(mk_row(ONE, 0, 0, 0, 1,
                                       mk_result(ONE, 0, ONE, 0, 0, ONE, 0)));
        // Rotation: negative discriminant, root forced to zero.
        directed_rows.push_back(mk_row(0, ONE, -ONE, 0, 1,
                                       mk_result(0, 0, 0, -ONE, 0, -ONE, 1)));
        // The rest go through the predictor.
        directed_rows.push_back(mk_row(QMAX, QMAX, QMAX, QMAX, 0, none));
        directed_rows.push_back(mk_row(QMIN, QMIN, QMIN, QMIN, 0, none));
        directed_rows.push_back(mk_row(QMAX, QMIN, QMAX, QMIN, 0, none));
        directed_rows.push_back(mk_row(QMIN, QMAX, QMIN, QMAX, 0, none));
        directed_rows.push_back(mk_row(0, QMAX, QMIN, 0, 0, none));
        directed_rows.push_back(mk_row(2 * ONE, ONE, 0, 3 * ONE, 0, none));
        directed_rows.push_back(mk_row(2 * ONE, 0, ONE, 3 * ONE, 0, none));
        directed_rows.push_back(mk_row(2 * ONE, ONE, ONE, 2 * ONE, 0, none));
        directed_rows.push_back(mk_row(1, -1, 1, -1, 0, none));
        directed_rows.push_back(mk_row(-1, -1, -1, -1, 0, none));
        directed_rows.push_back(mk_row(0, 0, QMIN, QMAX, 0, none));
        directed_rows.push_back(mk_row(QMAX, QMIN, 0, 0, 0, none));
        directed_rows.push_back(mk_row(0, 1, 1, 0, 0, none));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 5; phase++)
        begin
            drain_pipeline();
            // Settings walk: defaults, both off, and each one alone.
            write_reg(REG_SORT_ENABLE, phase inside {0, 2, 4});
            write_reg(REG_NORMALIZE_ENABLE, phase inside {0, 3, 4});
            cfg_we <= 1'b0;
            no_gaps = (phase == 1);
            rx_no_stall = (phase == 2);
            foreach (directed_rows[i])
            begin
                // Typed rows hold with normalization on or off and either order.
                send_matrix(directed_rows[i].a, directed_rows[i].b, directed_rows[i].c,
                            directed_rows[i].d, directed_rows[i].typed,
                            directed_rows[i].want, no_gaps);
            end
            for (int n = 0; n < 360; n++)
            begin
                a = rand_entry();
                b = rand_entry();
                c = rand_entry();
                d = rand_entry();
                if ($urandom_range(0, 5) == 0)
                    c = 0;
                if ($urandom_range(0, 7) == 0)
                    b = 0;
                send_matrix(a, b, c, d, 0, none, no_gaps);
            end
        end

        drain_pipeline();
        rx_no_stall = 1'b0;
        if (error_count == 0 && pending_results.size() == 0)
            $display("eigen_2x2_solver_core: match");
        else
            $display("eigen_2x2_solver_core: mismatch");
        $finish;
    end

endmodule
